// ----- hdl/pss_pkg.sv -----
`default_nettype none

package pss_pkg;

   // Widths of the channel fields.
   localparam int CMD_WIDTH       = 2;
   localparam int REQ_IDX_WIDTH   = 3;
   localparam int STATE_WIDTH     = 2;
   localparam int MASK_OUT_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CFG_WIDTH       = 16;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_REQUESTERS = 8;
   localparam int DEFAULT_TIMER_BITS = 16;

   // A deactivate delay of this value never expires.
   localparam logic [CFG_WIDTH-1:0] NEVER_DELAY = '1;

   // Configuration reset values.
   localparam logic                 RESET_PG_SENSE      = 1'b1;
   localparam logic [CFG_WIDTH-1:0] RESET_DEACT_DELAY   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] RESET_ACTIVATE_POLL = 16'd100;
   localparam logic [CFG_WIDTH-1:0] RESET_ACTIVE_POLL   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] RESET_INACTIVE_POLL = 16'd10000;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_INACTIVE   = 2'd0,
      ST_ACTIVATE   = 2'd1,
      ST_ACTIVE     = 2'd2,
      ST_DEACTIVATE = 2'd3
   } pss_state_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_REQ    = 2'd1,
      CMD_CLEAR_REQ  = 2'd2,
      CMD_PIN_CHANGE = 2'd3
   } pss_cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PG_SENSE      = 3'd0,
      CSR_DEACT_DELAY   = 3'd1,
      CSR_ACTIVATE_POLL = 3'd2,
      CSR_ACTIVE_POLL   = 3'd3,
      CSR_INACTIVE_POLL = 3'd4
   } pss_csr_index_type;

endpackage

`default_nettype wire

// ----- hdl/pss_if.sv -----
`default_nettype none

interface pss_req_if;
   import pss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_WIDTH-1:0]     command;
   logic [REQ_IDX_WIDTH-1:0] requester;
   logic                     power_good_level;

   modport source (output valid, command, requester, power_good_level, input ready);
   modport sink   (input valid, command, requester, power_good_level, output ready);
endinterface

interface pss_rsp_if;
   import pss_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      power_enable;
   logic                      power_good_flag;
   logic [STATE_WIDTH-1:0]    sequencer_state;
   logic [MASK_OUT_WIDTH-1:0] request_bits;

   modport source (output valid, power_enable, power_good_flag, sequencer_state,
                   request_bits, input ready);
   modport sink   (input valid, power_enable, power_good_flag, sequencer_state,
                   request_bits, output ready);
endinterface

interface pss_csr_if;
   import pss_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/power_supply_sequencer.sv -----
// Channel   Dir  Payload                                               Transfer when
// req_ch    in   command, requester, power_good_level                  valid && ready
// rsp_ch    out  power_enable, power_good_flag, sequencer_state,       valid && ready
//                request_bits
// csr_ch    in   index, data                                           valid && ready
//
// Every request transfer produces exactly one response, registered and presented in the following cycle.
// The sequencer state registers double as the response register, so one item
// is taken per cycle as long as the response side keeps up.
// While a response waits unclaimed, req_ch.ready drops; it rises again in the
// cycle that response is taken, so no bubble is inserted.
// Reset (synchronous, active high) restores the inactive state, an empty
// request mask, a disarmed countdown and the default configuration.
`default_nettype none

module power_supply_sequencer #(
   parameter int REQUESTERS = pss_pkg::DEFAULT_REQUESTERS,
   parameter int TIMER_BITS = pss_pkg::DEFAULT_TIMER_BITS
) (
   input  wire       clock,
   input  wire       reset,
   pss_req_if.sink   req_ch,
   pss_rsp_if.source rsp_ch,
   pss_csr_if.sink   csr_ch
);
   import pss_pkg::*;

   // Largest countdown value; wider loads are clipped to it.
   localparam logic [31:0] TIMER_MAX32 = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

   // Configuration registers.
   logic                 pg_sense_ff;
   logic [CFG_WIDTH-1:0] deact_delay_ff;
   logic [CFG_WIDTH-1:0] activate_poll_ff;
   logic [CFG_WIDTH-1:0] active_poll_ff;
   logic [CFG_WIDTH-1:0] inactive_poll_ff;

   // Sequencer state; it also holds the pending response payload.
   pss_state_type           state_ff, state_in;
   logic [REQUESTERS-1:0]   mask_ff, mask_in;
   logic [TIMER_BITS-1:0]   remaining_ff, remaining_in;
   logic                    armed_ff, armed_in;
   logic                    enable_ff, enable_in;
   logic                    good_ff, good_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic [REQUESTERS-1:0]   req_onehot;
   logic [31:0]             mask32;

   // Clip a configured interval to the countdown width.
   function automatic logic [TIMER_BITS-1:0] fit_timer(input logic [CFG_WIDTH-1:0] value);
      logic [31:0] value32;
      value32 = 32'(value);
      if (value32 > TIMER_MAX32) begin
         return TIMER_BITS'(TIMER_MAX32);
      end
      return TIMER_BITS'(value32);
   endfunction

   // A new item is taken when no response is pending or the pending one
   // leaves in this same cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   // Requester decode; an index beyond the requester count selects nothing,
   // so the mask stays unchanged while the event still wakes the machine as a valid index would.
   always_comb begin
      for (int i = 0; i < REQUESTERS; i++) begin
         req_onehot[i] = (32'(req_ch.requester) == 32'(i));
      end
   end

   // Next-state logic: mask update, countdown, then the state machine
   // evaluation when the event wakes it.
   always_comb begin
      logic                 wake;
      logic                 good;
      logic                 any;
      logic                 timeout;
      logic                 do_enter;
      logic                 may_be_never;
      pss_state_type        target;
      logic [CFG_WIDTH-1:0] interval;

      state_in     = state_ff;
      mask_in      = mask_ff;
      remaining_in = remaining_ff;
      armed_in     = armed_ff;
      enable_in    = enable_ff;
      good_in      = good_ff;
      wake         = 1'b0;
      do_enter     = 1'b0;
      may_be_never = 1'b0;
      target       = state_ff;
      interval     = inactive_poll_ff;

      good = !pg_sense_ff || req_ch.power_good_level;

      if (req_fire) begin
         unique case (req_ch.command)
            CMD_TICK: begin
               if (armed_ff) begin
                  if (remaining_ff != '0) begin
                     remaining_in = remaining_ff - 1'b1;
                  end
                  wake = (remaining_in == '0);
               end
            end
            CMD_SET_REQ: begin
               mask_in = mask_ff | req_onehot;
               wake    = (state_ff == ST_INACTIVE) || (state_ff == ST_DEACTIVATE);
            end
            CMD_CLEAR_REQ: begin
               mask_in = mask_ff & ~req_onehot;
               wake    = (state_ff == ST_ACTIVATE) || (state_ff == ST_ACTIVE);
            end
            CMD_PIN_CHANGE: begin
               wake = 1'b1;
            end
            default: begin
               wake = 1'b0;
            end
         endcase
      end

      any     = |mask_in;
      timeout = armed_ff && (remaining_in == '0);

      if (wake) begin
         good_in = good;
         unique case (state_ff)
            ST_INACTIVE: begin
               do_enter = 1'b1;
               if (any) begin
                  target    = ST_ACTIVATE;
                  interval  = activate_poll_ff;
                  enable_in = 1'b1;
               end else begin
                  target   = ST_INACTIVE;
                  interval = inactive_poll_ff;
               end
            end
            ST_ACTIVATE: begin
               priority if (!any) begin
                  do_enter     = 1'b1;
                  target       = ST_DEACTIVATE;
                  interval     = deact_delay_ff;
                  may_be_never = 1'b1;
               end else if (good) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVE;
                  interval = active_poll_ff;
               end else if (timeout) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVATE;
                  interval = activate_poll_ff;
               end else begin
                  do_enter = 1'b0;
               end
            end
            ST_ACTIVE: begin
               priority if (!any) begin
                  do_enter     = 1'b1;
                  target       = ST_DEACTIVATE;
                  interval     = deact_delay_ff;
                  may_be_never = 1'b1;
               end else if (!good) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVATE;
                  interval = activate_poll_ff;
               end else if (timeout) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVE;
                  interval = active_poll_ff;
               end else begin
                  do_enter = 1'b0;
               end
            end
            ST_DEACTIVATE: begin
               priority if (any && good) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVE;
                  interval = active_poll_ff;
               end else if (any) begin
                  do_enter = 1'b1;
                  target   = ST_ACTIVATE;
                  interval = activate_poll_ff;
               end else if (timeout) begin
                  // Delay ran out with nothing requested: power off.
                  do_enter  = 1'b1;
                  target    = ST_INACTIVE;
                  interval  = inactive_poll_ff;
                  enable_in = 1'b0;
                  good_in   = 1'b0;
               end else begin
                  do_enter = 1'b0;
               end
            end
            default: begin
               do_enter = 1'b0;
            end
         endcase
      end

      if (do_enter) begin
         state_in = target;
         if (may_be_never && (interval == NEVER_DELAY)) begin
            armed_in     = 1'b0;
            remaining_in = '0;
         end else begin
            armed_in     = 1'b1;
            remaining_in = fit_timer(interval);
         end
      end
   end

   // Response handshake: set by an accepted item, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INACTIVE;
         mask_ff      <= '0;
         remaining_ff <= '0;
         armed_ff     <= 1'b0;
         enable_ff    <= 1'b0;
         good_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         remaining_ff <= remaining_in;
         armed_ff     <= armed_in;
         enable_ff    <= enable_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pg_sense_ff      <= RESET_PG_SENSE;
         deact_delay_ff   <= RESET_DEACT_DELAY;
         activate_poll_ff <= RESET_ACTIVATE_POLL;
         active_poll_ff   <= RESET_ACTIVE_POLL;
         inactive_poll_ff <= RESET_INACTIVE_POLL;
      end else if (csr_fire) begin
         unique case (csr_ch.index)
            CSR_PG_SENSE:      pg_sense_ff      <= csr_ch.data[0];
            CSR_DEACT_DELAY:   deact_delay_ff   <= csr_ch.data;
            CSR_ACTIVATE_POLL: activate_poll_ff <= csr_ch.data;
            CSR_ACTIVE_POLL:   active_poll_ff   <= csr_ch.data;
            CSR_INACTIVE_POLL: inactive_poll_ff <= csr_ch.data;
            default: begin
               pg_sense_ff <= pg_sense_ff;
            end
         endcase
      end
   end

   // The response shows the state left by the last accepted item. The mask
   // is reported through its low bits, zero-filled for few requesters.
   assign mask32                 = 32'(mask_ff);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.power_enable    = enable_ff;
   assign rsp_ch.power_good_flag = good_ff;
   assign rsp_ch.sequencer_state = state_ff;
   assign rsp_ch.request_bits    = mask32[MASK_OUT_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- sim/power_supply_sequencer_checker.sv -----
`timescale 1ns / 1ps

module power_supply_sequencer_checker (
   input  wire  clock,
   input  wire  reset,
   pss_req_if   req_mon,
   pss_rsp_if   rsp_mon,
   pss_csr_if   csr_mon,
   output int   failures,
   output int   outstanding
);
   import pss_pkg::*;

   typedef struct packed {
      logic                      enable;
      logic                      good;
      pss_state_type             state;
      logic [MASK_OUT_WIDTH-1:0] bits;
   } supply_status_type;

   // Configuration as the block should hold it.
   logic                 pg_sense;
   logic [CFG_WIDTH-1:0] deact_delay;
   logic [CFG_WIDTH-1:0] activate_poll;
   logic [CFG_WIDTH-1:0] active_poll;
   logic [CFG_WIDTH-1:0] inactive_poll;

   // Sequencer state as the block should hold it.
   pss_state_type        seq_state;
   logic [7:0]           held_mask;
   logic [CFG_WIDTH-1:0] countdown;
   logic                 countdown_armed;
   logic                 enable_now;
   logic                 good_now;

   supply_status_type status_q[$];
   int fault_total   = 0;
   int waiting_total = 0;

   assign failures    = fault_total;
   assign outstanding = waiting_total;

   task automatic restore_defaults();
      pg_sense        = RESET_PG_SENSE;
      deact_delay     = RESET_DEACT_DELAY;
      activate_poll   = RESET_ACTIVATE_POLL;
      active_poll     = RESET_ACTIVE_POLL;
      inactive_poll   = RESET_INACTIVE_POLL;
      seq_state       = ST_INACTIVE;
      held_mask       = '0;
      countdown       = '0;
      countdown_armed = 1'b0;
      enable_now      = 1'b0;
      good_now        = 1'b0;
   endtask

   // Entering a state reloads the countdown; only the deactivate delay may be "never".
   task automatic enter_state(input pss_state_type next, input logic [CFG_WIDTH-1:0] ticks,
                              input bit may_be_never);
      seq_state = next;
      if (may_be_never && ticks == NEVER_DELAY) begin
         countdown_armed = 1'b0;
         countdown       = '0;
      end else begin
         countdown_armed = 1'b1;
         countdown       = ticks;
      end
   endtask

   task automatic reevaluate_supply(input logic level);
      bit expired;
      bit good;
      bit any_held;
      expired  = countdown_armed && countdown == 0;
      good     = !pg_sense || level;
      any_held = held_mask != 0;
      good_now = good;
      case (seq_state)
         ST_INACTIVE: begin
            if (any_held) begin
               enter_state(ST_ACTIVATE, activate_poll, 1'b0);
               enable_now = 1'b1;
            end else begin
               enter_state(ST_INACTIVE, inactive_poll, 1'b0);
            end
         end
         ST_ACTIVATE: begin
            if (!any_held)    enter_state(ST_DEACTIVATE, deact_delay, 1'b1);
            else if (good)    enter_state(ST_ACTIVE, active_poll, 1'b0);
            else if (expired) enter_state(ST_ACTIVATE, activate_poll, 1'b0);
         end
         ST_ACTIVE: begin
            if (!any_held)    enter_state(ST_DEACTIVATE, deact_delay, 1'b1);
            else if (!good)   enter_state(ST_ACTIVATE, activate_poll, 1'b0);
            else if (expired) enter_state(ST_ACTIVE, active_poll, 1'b0);
         end
         default: begin
            if (any_held && good) begin
               enter_state(ST_ACTIVE, active_poll, 1'b0);
            end else if (any_held) begin
               enter_state(ST_ACTIVATE, activate_poll, 1'b0);
            end else if (expired) begin
               enable_now = 1'b0;
               good_now   = 1'b0;
               enter_state(ST_INACTIVE, inactive_poll, 1'b0);
            end
         end
      endcase
   endtask

   task automatic apply_command(input pss_cmd_type op, input logic [2:0] who,
                                input logic level);
      bit wake;
      wake = 1'b0;
      case (op)
         CMD_TICK: begin
            if (countdown_armed) begin
               if (countdown != 0) countdown = countdown - 1'b1;
               if (countdown == 0) wake = 1'b1;
            end
         end
         CMD_SET_REQ: begin
            held_mask = held_mask | (8'b1 << who);
            wake = seq_state == ST_INACTIVE || seq_state == ST_DEACTIVATE;
         end
         CMD_CLEAR_REQ: begin
            held_mask = held_mask & ~(8'b1 << who);
            wake = seq_state == ST_ACTIVATE || seq_state == ST_ACTIVE;
         end
         default: wake = 1'b1;
      endcase
      if (wake) reevaluate_supply(level);
      status_q.push_back('{enable_now, good_now, seq_state, held_mask});
   endtask

   always @(posedge clock) begin
      supply_status_type want;
      supply_status_type got;
      if (reset) begin
         restore_defaults();
         status_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (pss_csr_index_type'(csr_mon.index))
               CSR_PG_SENSE:      pg_sense      = csr_mon.data[0];
               CSR_DEACT_DELAY:   deact_delay   = csr_mon.data;
               CSR_ACTIVATE_POLL: activate_poll = csr_mon.data;
               CSR_ACTIVE_POLL:   active_poll   = csr_mon.data;
               CSR_INACTIVE_POLL: inactive_poll = csr_mon.data;
               default: ;
            endcase
         end
         // The response of this edge belongs to an earlier request, so it is
         // checked before the request of this edge is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.power_enable, rsp_mon.power_good_flag,
                    pss_state_type'(rsp_mon.sequencer_state), rsp_mon.request_bits};
            if (status_q.size() == 0) begin
               if (fault_total < 10)
                  $display("%0t: response with no request outstanding: enable=%0b good=%0b ",
                           $time, got.enable, got.good,
                           "state=%0d mask=%02h", got.state, got.bits);
               fault_total++;
            end else begin
               want = status_q.pop_front();
               if (want.enable !== got.enable || want.good !== got.good ||
                   want.state !== got.state || want.bits !== got.bits) begin
                  if (fault_total < 10)
                     $display("%0t: mismatch: expected enable=%0b good=%0b state=%0d mask=%02h,",
                              $time, want.enable, want.good, want.state, want.bits,
                              " got enable=%0b good=%0b state=%0d mask=%02h",
                              got.enable, got.good, got.state, got.bits);
                  fault_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_command(pss_cmd_type'(req_mon.command), req_mon.requester,
                          req_mon.power_good_level);
      end
      waiting_total <= status_q.size();
   end

endmodule

// ----- sim/power_supply_sequencer_tb.sv -----
`timescale 1ns / 1ps

module power_supply_sequencer_tb;
   import pss_pkg::*;

   // An index that names no register; a write to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NO_REGISTER = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Set while random sender gaps and receiver stalls are allowed. The last
   // phase of the run clears it so that the block also sees full throughput.
   bit idling_on = 1'b1;

   int failures;
   int outstanding;

   pss_req_if req_ch ();
   pss_rsp_if rsp_ch ();
   pss_csr_if csr_ch ();

   power_supply_sequencer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // The checker watches all three channels, predicts every response and
   // reports how many responses went wrong and how many are still due.
   power_supply_sequencer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   // Hard limit on the run. A correct run needs well under a tenth of this,
   // even with every transfer delayed by the longest gap and stall.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Response side: ready drops in random bursts while idling
   // is allowed, and stays high otherwise.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Presents one request and returns right after the edge of its transfer.
   // Valid is only lowered for a gap, so back-to-back items keep it high.
   task automatic send_item(input pss_cmd_type op, input logic [REQ_IDX_WIDTH-1:0] who,
                            input logic level);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.command          <= op;
      req_ch.requester        <= who;
      req_ch.power_good_level <= level;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops sending and waits until every predicted response has been taken.
   // The block answers each transfer from its response register, so a short
   // pause after that is enough to be sure it is idle.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CFG_WIDTH-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Reprograms every register, always from an idle block.
   task automatic program_supply(input logic [CFG_WIDTH-1:0] pg_word,
                                 input logic [CFG_WIDTH-1:0] deact,
                                 input logic [CFG_WIDTH-1:0] act_poll,
                                 input logic [CFG_WIDTH-1:0] on_poll,
                                 input logic [CFG_WIDTH-1:0] off_poll);
      drain_responses();
      write_register(CSR_PG_SENSE, pg_word);
      write_register(CSR_DEACT_DELAY, deact);
      write_register(CSR_ACTIVATE_POLL, act_poll);
      write_register(CSR_ACTIVE_POLL, on_poll);
      write_register(CSR_INACTIVE_POLL, off_poll);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic draw_level(input int bad_percent);
      return $urandom_range(0, 99) >= bad_percent;
   endfunction

   // Random traffic shaped like real use: runs of ticks so that countdowns
   // expire, requests mostly from two requesters so that the mask often
   // empties and the supply gets switched off, and pin changes in between.
   task automatic run_random_phase(input int quota, input int bad_percent);
      int sent;
      int pick;
      int run;
      logic [REQ_IDX_WIDTH-1:0] who;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0)
            who = REQ_IDX_WIDTH'($urandom_range(0, 7));
         else
            who = REQ_IDX_WIDTH'($urandom_range(0, 1));
         if (pick < 40) begin
            run = $urandom_range(1, 12);
            repeat (run)
               send_item(CMD_TICK, REQ_IDX_WIDTH'($urandom), draw_level(bad_percent));
            sent += run;
         end else begin
            if (pick < 55)
               send_item(CMD_SET_REQ, who, draw_level(bad_percent));
            else if (pick < 75)
               send_item(CMD_CLEAR_REQ, who, draw_level(bad_percent));
            else
               send_item(CMD_PIN_CHANGE, who, draw_level(bad_percent));
            sent++;
         end
      end
   endtask

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.command          <= CMD_TICK;
      req_ch.requester        <= '0;
      req_ch.power_good_level <= 1'b0;
      csr_ch.valid            <= 1'b0;
      csr_ch.index            <= CSR_PG_SENSE;
      csr_ch.data             <= '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk through the state machine with the reset configuration.
      // A tick right after reset finds no armed countdown and changes nothing.
      send_item(CMD_TICK, 3'd0, 1'b1);
      // Pin changes while inactive reload the idle countdown and track the pin.
      send_item(CMD_PIN_CHANGE, 3'd0, 1'b0);
      send_item(CMD_PIN_CHANGE, 3'd7, 1'b1);
      // The first request powers up; a good pin then reaches the active state.
      send_item(CMD_SET_REQ, 3'd7, 1'b1);
      send_item(CMD_PIN_CHANGE, 3'd0, 1'b1);
      // A second request while active does not wake the machine.
      send_item(CMD_SET_REQ, 3'd0, 1'b0);
      // Power going bad falls back to activate, and recovers.
      send_item(CMD_PIN_CHANGE, 3'd0, 1'b0);
      send_item(CMD_TICK, 3'd5, 1'b0);
      send_item(CMD_PIN_CHANGE, 3'd2, 1'b1);
      // Dropping one of two requests keeps the supply on.
      send_item(CMD_CLEAR_REQ, 3'd7, 1'b1);
      // Dropping the last one starts the switch-off delay.
      send_item(CMD_CLEAR_REQ, 3'd0, 1'b1);
      // A request during that delay with a bad pin goes back to activate.
      send_item(CMD_SET_REQ, 3'd3, 1'b0);
      // A request while activating does not wake the machine.
      send_item(CMD_SET_REQ, 3'd5, 1'b1);
      send_item(CMD_CLEAR_REQ, 3'd3, 1'b0);
      send_item(CMD_CLEAR_REQ, 3'd5, 1'b1);
      // A request during the delay with a good pin goes straight to active.
      send_item(CMD_SET_REQ, 3'd6, 1'b1);
      send_item(CMD_CLEAR_REQ, 3'd6, 1'b1);
      // Clearing an empty mask while deactivating does not wake the machine.
      send_item(CMD_CLEAR_REQ, 3'd6, 1'b0);
      send_item(CMD_TICK, 3'd7, 1'b0);
      send_item(CMD_TICK, 3'd0, 1'b1);
      send_item(CMD_SET_REQ, 3'd4, 1'b1);
      send_item(CMD_CLEAR_REQ, 3'd1, 1'b0);

      // Short intervals so that every countdown runs out often. The write to
      // an unused index must leave the configuration alone.
      program_supply(16'h0001, 16'd3, 16'd2, 16'd5, 16'd4);
      write_register(CSR_NO_REGISTER, 16'hFFFF);
      csr_ch.valid <= 1'b0;
      run_random_phase(300, 20);

      // No power-good sense: the pin is ignored. The upper data bits of the
      // sense register are set to show that only bit zero counts. A zero
      // switch-off delay powers down at the next tick or wake.
      program_supply(16'hFFFE, 16'd0, 16'd1, 16'd1, 16'd1);
      run_random_phase(250, 50);

      // A switch-off delay that never expires, and zero poll intervals that
      // are already due when they are loaded.
      program_supply(16'h0001, NEVER_DELAY, 16'd0, 16'd0, 16'd0);
      run_random_phase(250, 30);

      // The widest values: every poll is a full count, the delay one short of
      // never, so the machine moves on pin changes and requests alone.
      program_supply(16'h0001, 16'd65534, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(250, 30);

      // A random short configuration.
      program_supply(CFG_WIDTH'($urandom), CFG_WIDTH'($urandom_range(0, 10)),
                     CFG_WIDTH'($urandom_range(0, 6)), CFG_WIDTH'($urandom_range(0, 6)),
                     CFG_WIDTH'($urandom_range(0, 6)));
      run_random_phase(250, 25);

      // Last phase at full rate: no gaps and no stalls.
      program_supply(16'h0001, 16'd2, 16'd1, 16'd3, 16'd2);
      idling_on = 1'b0;
      run_random_phase(300, 15);

      drain_responses();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/pss_pkg.sv
hdl/pss_if.sv
hdl/power_supply_sequencer.sv
sim/power_supply_sequencer_checker.sv
sim/power_supply_sequencer_tb.sv
